@@ hdl/eprk_pkg.sv @@
// shared constants, codes and types of the envelope percentile rank block
package eprk_pkg;

    localparam int NUM_VARS_DEF  = 16;
    localparam int REF_DEPTH_DEF = 1024;

    localparam logic [10:0] REF_COUNT_RST = 11'd1024;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_BOTH = 2'd1;
    localparam logic [1:0] TAIL_HIGH = 2'd2;
    localparam logic [1:0] TAIL_LOW  = 2'd3;

    // request from the control unit to the search unit
    typedef struct packed {
        logic               start;
        logic signed [31:0] y;
    } t_srch_req;

endpackage

@@ hdl/eprk_in_if.sv @@
// input word channel
interface eprk_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [3:0]         var_index;
    logic [9:0]         slot_index;
    logic signed [31:0] value;
    logic signed [31:0] upper_bound;
    logic [1:0]         tail_mode;
    logic               value_finite;
    logic               last_variable;

    modport source (output valid, action, var_index, slot_index, value, upper_bound,
                    tail_mode, value_finite, last_variable, input ready);
    modport sink (input valid, action, var_index, slot_index, value, upper_bound,
                  tail_mode, value_finite, last_variable, output ready);
endinterface

@@ hdl/eprk_out_if.sv @@
// result word channel
interface eprk_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] score;
    logic        score_na;

    modport source (output valid, score, score_na, input ready);
    modport sink (input valid, score, score_na, output ready);
endinterface

@@ hdl/eprk_cfg_if.sv @@
// configuration write channel
interface eprk_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hdl/eprk_ram.sv @@
// generic simple dual port ram with registered read
module eprk_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/eprk_search.sv @@
// two-pass binary search over one sorted reference column
module eprk_search #(
    parameter int NUM_VARS  = eprk_pkg::NUM_VARS_DEF,
    parameter int REF_DEPTH = eprk_pkg::REF_DEPTH_DEF,
    localparam int CW = $clog2(REF_DEPTH + 1),
    localparam int AW = $clog2(NUM_VARS * REF_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eprk_pkg::t_srch_req i_req,
    input  logic [3:0]          i_var,
    input  logic [CW-1:0]       i_n,
    output logic [AW-1:0]       o_raddr,
    input  logic [31:0]         i_rdata,
    output logic                o_done,
    output logic [CW-1:0]       o_b,
    output logic [CW-1:0]       o_e
);
    import eprk_pkg::*;

    typedef enum logic [2:0] {
        SR_IDLE  = 3'b001,
        SR_ISSUE = 3'b010,
        SR_CMP   = 3'b100
    } t_sr_state;

    t_sr_state          r_state;
    logic [CW-1:0]      r_lo, r_hi, r_mid, r_b;
    logic               r_pass, r_done;
    logic signed [31:0] r_y;
    logic [AW-1:0]      r_base;
    logic [CW:0]        sum_c;
    logic [CW-1:0]      mid_c;
    logic               go_right;

    assign sum_c    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c    = sum_c[CW:1];
    assign o_raddr  = r_base + AW'(mid_c);
    // pass 0 finds the first entry not below y, pass 1 the first entry above y
    assign go_right = r_pass ? ($signed(i_rdata) <= r_y) : ($signed(i_rdata) < r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
            r_done  <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_done <= (r_state == SR_ISSUE) && !(r_lo < r_hi) && r_pass;
            unique case (r_state)
                SR_IDLE: begin
                    if (i_req.start) begin
                        r_y     <= i_req.y;
                        r_base  <= AW'(i_var) * AW'(REF_DEPTH);
                        r_lo    <= '0;
                        r_hi    <= i_n;
                        r_pass  <= 1'b0;
                        r_state <= SR_ISSUE;
                    end
                end
                SR_ISSUE: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid_c;
                        r_state <= SR_CMP;
                    end else if (!r_pass) begin
                        r_b    <= r_lo;
                        r_hi   <= i_n;
                        r_pass <= 1'b1;
                    end else begin
                        r_state <= SR_IDLE;
                    end
                end
                SR_CMP: begin
                    if (go_right) begin
                        r_lo <= r_mid + CW'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= SR_ISSUE;
                end
                default: r_state <= SR_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_b    = r_b;
    assign o_e    = r_lo;
endmodule

@@ hdl/eprk_div.sv @@
// restoring divider, one quotient bit a cycle, for the q1.16 scaling
module eprk_div #(
    parameter int MW = 12,
    localparam int NW = MW + 16,
    localparam int KW = $clog2(NW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    output logic          o_done,
    output logic [16:0]   o_quot
);
    logic [NW-1:0] r_num, r_q;
    logic [MW:0]   r_rem;
    logic [MW-1:0] r_den;
    logic [KW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [MW:0]   rem_sh;
    logic          qbit;

    assign rem_sh = {r_rem[MW-1:0], r_num[NW-1]};
    assign qbit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == KW'(1));
            if (i_start) begin
                r_num  <= {i_num, 16'd0};
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= KW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= qbit ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[NW-2:0], qbit};
                r_num <= {r_num[NW-2:0], 1'b0};
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[16:0];
endmodule

@@ hdl/envelope_percentile_rank_top.sv @@
// top level of the envelope percentile rank scorer
//  channel  dir  handshake      words
//  i_in     in   valid/ready    load, set bounds, query
//  o_out    out  valid/ready    row score and na flag
//  i_cfg    in   valid/ready    ref_count, always ready
// loads and sets are taken in the idle state; a query runs two binary searches with
// k0 and k1 probes (each at most log2(n)+1, one ram read per probe); a value outside
// its bounds skips both searches
// the last query of a row also runs the bit-serial divider
// reset is synchronous active low; the rams need no clearing pass
// while a row result waits for the previous word to leave, no input is taken
module envelope_percentile_rank_top #(
    parameter int NUM_VARS  = eprk_pkg::NUM_VARS_DEF,
    parameter int REF_DEPTH = eprk_pkg::REF_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    eprk_in_if.sink    i_in,
    eprk_out_if.source o_out,
    eprk_cfg_if.sink   i_cfg
);
    import eprk_pkg::*;

    localparam int CW = $clog2(REF_DEPTH + 1);
    localparam int AW = $clog2(NUM_VARS * REF_DEPTH);
    localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int MW = $clog2(2 * REF_DEPTH + 1);
    localparam int SW = $clog2(4 * REF_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_BOUND  = 7'b0000010,
        ST_SEARCH = 7'b0000100,
        ST_SCORE  = 7'b0001000,
        ST_ROW    = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_FIN    = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [10:0]        r_ref_count;
    logic signed [31:0] r_y;
    logic [3:0]         r_var;
    logic               r_last, r_na;
    logic [MW-1:0]      r_min;
    logic               r_out_valid, r_res_na;
    logic [16:0]        r_res_score;

    logic               in_acc;
    logic [CW-1:0]      n_eff;
    logic               ref_we, par_we;
    logic [AW-1:0]      ref_waddr, ref_raddr;
    logic [31:0]        ref_rdata;
    logic [VW-1:0]      par_addr;
    logic [65:0]        par_rdata;
    t_srch_req          srch_req;
    logic               srch_done, div_start, div_done;
    logic [CW-1:0]      srch_b, srch_e;
    logic [16:0]        div_quot;
    logic [SW-1:0]      r_sum, n_w, d_w, s_w;
    logic [MW-1:0]      m_clamp;
    logic               in_bounds;

    // effective count: zero reads as one, above the depth reads as the depth
    always_comb begin
        if (r_ref_count == 11'd0) begin
            n_eff = CW'(1);
        end else if (32'(r_ref_count) > 32'(REF_DEPTH)) begin
            n_eff = CW'(REF_DEPTH);
        end else begin
            n_eff = CW'(r_ref_count);
        end
    end

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign ref_we    = in_acc && (i_in.action == ACT_LOAD) &&
                       (32'(i_in.var_index) < 32'(NUM_VARS)) &&
                       (32'(i_in.slot_index) < 32'(REF_DEPTH));
    assign ref_waddr = AW'(i_in.var_index) * AW'(REF_DEPTH) + AW'(i_in.slot_index);
    assign par_we    = in_acc && (i_in.action == ACT_SET) &&
                       (32'(i_in.var_index) < 32'(NUM_VARS));
    assign par_addr  = VW'(i_in.var_index);

    eprk_ram #(.W(32), .DEPTH(NUM_VARS * REF_DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (i_in.value),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    // one word per variable: tail, upper bound, lower bound
    eprk_ram #(.W(66), .DEPTH(NUM_VARS)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_addr),
        .i_wdata ({i_in.tail_mode, i_in.upper_bound, i_in.value}),
        .i_raddr (par_addr),
        .o_rdata (par_rdata)
    );

    assign in_bounds = !((r_y < $signed(par_rdata[31:0])) ||
                         (r_y > $signed(par_rdata[63:32])));

    assign srch_req.start = (r_state == ST_BOUND) && in_bounds;
    assign srch_req.y     = r_y;

    eprk_search #(.NUM_VARS(NUM_VARS), .REF_DEPTH(REF_DEPTH)) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (srch_req),
        .i_var   (r_var),
        .i_n     (n_eff),
        .o_raddr (ref_raddr),
        .i_rdata (ref_rdata),
        .o_done  (srch_done),
        .o_b     (srch_b),
        .o_e     (srch_e)
    );

    logic [1:0] r_tail;

    // r = 2b + t = b + e
    assign n_w = SW'(n_eff);
    assign d_w = SW'(n_eff) << 1;
    always_comb begin
        r_sum = SW'(srch_b) + SW'(srch_e);
        case (r_tail)
            TAIL_BOTH: s_w = (r_sum <= n_w) ? (r_sum << 1) : ((d_w << 1) - (r_sum << 1));
            TAIL_HIGH: s_w = (r_sum < n_w) ? d_w : ((d_w << 1) - (r_sum << 1));
            TAIL_LOW:  s_w = (r_sum > n_w) ? d_w : (r_sum << 1);
            default:   s_w = r_sum;
        endcase
    end

    assign m_clamp   = (SW'(r_min) > d_w) ? MW'(d_w) : r_min;
    assign div_start = (r_state == ST_ROW) && r_last && !r_na;

    eprk_div #(.MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (m_clamp),
        .i_den   (MW'(d_w)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ref_count <= REF_COUNT_RST;
            r_min       <= '1;
            r_na        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_ref_count <= i_cfg.data;
            end
            if ((r_state == ST_FIN) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.action == ACT_QUERY)) begin
                        r_y    <= i_in.value;
                        r_var  <= i_in.var_index;
                        r_last <= i_in.last_variable;
                        if (r_na) begin
                            r_state <= ST_ROW;
                        end else if (!i_in.value_finite) begin
                            r_na    <= 1'b1;
                            r_state <= ST_ROW;
                        end else if (32'(i_in.var_index) >= 32'(NUM_VARS)) begin
                            r_state <= ST_ROW;
                        end else begin
                            r_state <= ST_BOUND;
                        end
                    end
                end
                ST_BOUND: begin
                    r_tail <= par_rdata[65:64];
                    if (in_bounds) begin
                        r_state <= ST_SEARCH;
                    end else begin
                        r_min   <= '0;
                        r_state <= ST_ROW;
                    end
                end
                ST_SEARCH: begin
                    if (srch_done) begin
                        r_state <= ST_SCORE;
                    end
                end
                ST_SCORE: begin
                    if (s_w < SW'(r_min)) begin
                        r_min <= MW'(s_w);
                    end
                    r_state <= ST_ROW;
                end
                ST_ROW: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (r_na) begin
                        r_res_score <= '0;
                        r_res_na    <= 1'b1;
                        r_state     <= ST_FIN;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_res_score <= div_quot;
                        r_res_na    <= 1'b0;
                        r_state     <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // wait until the previous word has left
                    if (!r_out_valid || o_out.ready) begin
                        r_min   <= '1;
                        r_na    <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic [16:0] r_out_score;
    logic        r_out_na;

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && (!r_out_valid || o_out.ready)) begin
            r_out_score <= r_res_score;
            r_out_na    <= r_res_na;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.score    = r_out_score;
    assign o_out.score_na = r_out_na;

`ifndef ASSERT_OFF
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result word raised outside the finish state");
    a_srch_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_done |-> (r_state == ST_SEARCH))
        else $error("search finished while control was not waiting");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished while control was not waiting");
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCORE) |=> ((r_min == '1) || (SW'(r_min) <= d_w)))
        else $error("running minimum above the scale");
`endif
endmodule
